>>> rtl/ptw_pkg.sv
`timescale 1ns / 1ps
package ptw_pkg;

  localparam int TABLE_PAGES = 16;
  localparam int ENTRIES     = 512;
  localparam int IDX_W       = 9;
  localparam int FRAME_W     = 40;
  localparam int PAGE_W      = $clog2(TABLE_PAGES);
  localparam int NFREE_W     = $clog2(TABLE_PAGES + 1);
  localparam int MEM_AW      = PAGE_W + IDX_W;
  localparam int MEM_DEPTH   = TABLE_PAGES * ENTRIES;

  localparam logic [11:0] TABLE_FLAGS = 12'h007;

  localparam logic [1:0] CMD_TRANSLATE = 2'd0;
  localparam logic [1:0] CMD_MAP       = 2'd1;
  localparam logic [1:0] CMD_UNMAP     = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED  = 2'd2;
  localparam logic [1:0] ST_OUTSIDE    = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [47:0] virt_addr;
    logic [51:0] map_page_addr;
    logic [63:0] entry_flags;
  } in_item_t;

  typedef struct packed {
    logic [51:0] phys_result;
    logic [1:0]  status;
    logic        flush_request;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_CHK,
    S_ALLOC,
    S_RANGE,
    S_DONE
  } walk_state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic [FRAME_W-1:0] a;
    logic [FRAME_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] res;
    logic               carry;
  } alu_rsp_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] addr;
    logic [63:0]       wdata;
  } mem_req_t;

endpackage

>>> rtl/ptw_alu.sv
`timescale 1ns / 1ps
module ptw_alu import ptw_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [FRAME_W:0] sum;

  always_comb begin
    case (req.op)
      ALU_ADD: sum = {1'b0, req.a} + {1'b0, req.b};
      ALU_SUB: sum = {1'b0, req.a} - {1'b0, req.b};
      default: sum = '0;
    endcase
    rsp.res   = sum[FRAME_W-1:0];
    rsp.carry = sum[FRAME_W];
  end

endmodule

>>> rtl/ptw_seq.sv
`timescale 1ns / 1ps
module ptw_seq import ptw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  in_item_t           in_item,
  output logic               busy,
  input  logic [FRAME_W-1:0] pool_base_frame,
  output mem_req_t           mem_req,
  input  logic [63:0]        mem_rdata,
  output alu_req_t           alu_req,
  input  alu_rsp_t           alu_rsp,
  output logic               out_valid,
  output out_item_t          out_item
);

  walk_state_t        state_r, state_nxt;
  logic [MEM_AW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [1:0]         cmd_r, cmd_nxt;
  logic [47:0]        va_r, va_nxt;
  logic [63:0]        leaf_r, leaf_nxt;
  logic [63:0]        entry_r, entry_nxt;
  logic [1:0]         level_r, level_nxt;
  logic [PAGE_W-1:0]  page_r, page_nxt;
  logic [NFREE_W-1:0] nfree_r, nfree_nxt;
  logic [51:0]        phys_r, phys_nxt;
  logic [1:0]         status_r, status_nxt;
  logic               flush_r, flush_nxt;

  logic [MEM_AW-1:0]  walk_addr;
  logic               outside;
  logic               pool_full;
  logic [63:0]        alloc_entry;

  function automatic logic [IDX_W-1:0] level_idx(input logic [47:0] va,
                                                  input logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      2'd0:    idx = va[20:12];
      2'd1:    idx = va[29:21];
      2'd2:    idx = va[38:30];
      default: idx = va[47:39];
    endcase
    return idx;
  endfunction

  assign walk_addr   = {page_r, level_idx(va_r, level_r)};
  assign outside     = alu_rsp.carry || (alu_rsp.res >= FRAME_W'(TABLE_PAGES));
  assign pool_full   = (nfree_r == NFREE_W'(TABLE_PAGES));
  assign alloc_entry = {12'b0, alu_rsp.res, TABLE_FLAGS};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == MEM_AW'(MEM_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (in_item.cmd == CMD_TRANSLATE || in_item.cmd == CMD_MAP ||
              in_item.cmd == CMD_UNMAP) begin
            state_nxt = S_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_RD: begin
        if (level_r == 2'd0 && cmd_r != CMD_TRANSLATE) state_nxt = S_DONE;
        else state_nxt = S_CHK;
      end
      S_CHK: begin
        if (level_r == 2'd0) state_nxt = S_DONE;
        else if (mem_rdata[0]) state_nxt = S_RANGE;
        else if (cmd_r == CMD_MAP && !pool_full) state_nxt = S_ALLOC;
        else state_nxt = S_DONE;
      end
      S_ALLOC: state_nxt = S_RANGE;
      S_RANGE: begin
        if (outside) state_nxt = S_DONE;
        else state_nxt = S_RD;
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // shared unit operands
  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a  = pool_base_frame;
    alu_req.b  = FRAME_W'(nfree_r);
    if (state_r == S_RANGE) begin
      alu_req.op = ALU_SUB;
      alu_req.a  = entry_r[51:12];
      alu_req.b  = pool_base_frame;
    end
  end

  // datapath and outputs
  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    cmd_nxt     = cmd_r;
    va_nxt      = va_r;
    leaf_nxt    = leaf_r;
    entry_nxt   = entry_r;
    level_nxt   = level_r;
    page_nxt    = page_r;
    nfree_nxt   = nfree_r;
    phys_nxt    = phys_r;
    status_nxt  = status_r;
    flush_nxt   = flush_r;
    mem_req.we    = 1'b0;
    mem_req.addr  = walk_addr;
    mem_req.wdata = '0;
    case (state_r)
      S_CLEAR: begin
        mem_req.we   = 1'b1;
        mem_req.addr = clr_cnt_r;
        clr_cnt_nxt  = clr_cnt_r + 1'b1;
      end
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_item.cmd;
          va_nxt    = in_item.virt_addr;
          leaf_nxt  = {12'b0, in_item.map_page_addr} | in_item.entry_flags;
          level_nxt = 2'd3;
          page_nxt  = '0;
          phys_nxt  = '0;
          flush_nxt = 1'b0;
          if (in_item.cmd == CMD_TRANSLATE || in_item.cmd == CMD_MAP ||
              in_item.cmd == CMD_UNMAP) begin
            status_nxt = ST_OK;
          end else begin
            status_nxt = ST_NOT_MAPPED;
          end
        end
      end
      S_RD: begin
        if (level_r == 2'd0 && cmd_r == CMD_MAP) begin
          mem_req.we    = 1'b1;
          mem_req.wdata = leaf_r;
        end else if (level_r == 2'd0 && cmd_r == CMD_UNMAP) begin
          mem_req.we = 1'b1;
          flush_nxt  = 1'b1;
        end
      end
      S_CHK: begin
        if (level_r == 2'd0) begin
          phys_nxt = {mem_rdata[51:12], 12'b0};
        end else if (mem_rdata[0]) begin
          entry_nxt = mem_rdata;
        end else if (cmd_r == CMD_MAP) begin
          if (pool_full) status_nxt = ST_EXHAUSTED;
        end else if (cmd_r == CMD_UNMAP) begin
          mem_req.we = 1'b1;
          status_nxt = ST_NOT_MAPPED;
        end else begin
          status_nxt = ST_NOT_MAPPED;
        end
      end
      S_ALLOC: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = alloc_entry;
        entry_nxt     = alloc_entry;
        nfree_nxt     = nfree_r + 1'b1;
      end
      S_RANGE: begin
        if (outside) begin
          status_nxt = ST_OUTSIDE;
        end else begin
          page_nxt  = alu_rsp.res[PAGE_W-1:0];
          level_nxt = level_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      nfree_r   <= NFREE_W'(1);
      status_r  <= ST_OK;
      flush_r   <= 1'b0;
      phys_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      nfree_r   <= nfree_nxt;
      status_r  <= status_nxt;
      flush_r   <= flush_nxt;
      phys_r    <= phys_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    va_r    <= va_nxt;
    leaf_r  <= leaf_nxt;
    entry_r <= entry_nxt;
    level_r <= level_nxt;
    page_r  <= page_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_item.phys_result   = phys_r;
  assign out_item.status        = status_r;
  assign out_item.flush_request = flush_r;

endmodule

>>> rtl/four_level_page_table_walker_unit.sv
`timescale 1ns / 1ps
// channel   ports                         beat taken when
// request   start, busy, in_item          start high while busy low
// result    out_valid, out_item           out_valid high, one cycle
// config    cfg_we, cfg_wdata             cfg_we high
//
// a request with an unknown command goes straight to its result; a map that
// allocates at every level takes longest: each level costs a table read, a check
// and a pass through the shared 40-bit add/subtract unit with carry out, plus an
// allocation step per allocated table. reset clears all 8192 table memory entries,
// one entry a cycle, with busy high. the result cannot be stalled.
module four_level_page_table_walker_unit import ptw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_item_t           in_item,
  output logic               out_valid,
  output out_item_t          out_item,
  input  logic               cfg_we,
  input  logic [FRAME_W-1:0] cfg_wdata
);

  logic [FRAME_W-1:0] base_frame_r;
  logic [63:0]        table_mem [MEM_DEPTH];
  logic [63:0]        rdata_r;
  mem_req_t           mem_req;
  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_frame_r <= '0;
    end else if (cfg_we) begin
      base_frame_r <= cfg_wdata;
    end
  end

  // page table store
  always_ff @(posedge clk) begin
    if (mem_req.we) table_mem[mem_req.addr] <= mem_req.wdata;
    rdata_r <= table_mem[mem_req.addr];
  end

  ptw_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  ptw_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_item         (in_item),
    .busy            (busy),
    .pool_base_frame (base_frame_r),
    .mem_req         (mem_req),
    .mem_rdata       (rdata_r),
    .alu_req         (alu_req),
    .alu_rsp         (alu_rsp),
    .out_valid       (out_valid),
    .out_item        (out_item)
  );

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_flush_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.flush_request) |-> (out_item.status == ST_OK))
    else $error("flush raised on a failed request");

  a_phys_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.phys_result != '0)) |-> (out_item.status == ST_OK))
    else $error("address returned on a failed request");

endmodule
